@@ rtl/core/bwp_pkg.sv @@
// Shared types, constants and helpers of the bit width packer.
package bwp_pkg;

   localparam int unsigned MAX_ELEMENTS = 255;
   localparam int unsigned BYTES_PER_WORD = 8;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_HEAD,
      ST_NIB_RD,
      ST_NIB_USE,
      ST_PAY_RD,
      ST_PAY_LOAD,
      ST_PAY_BIT,
      ST_FLUSH,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic push;
      logic finish;
   } asm_ctl_type;

   function automatic logic [3:0] sig_len(input logic [7:0] v);
      logic [3:0] len;
      len = 4'd0;
      for (int k = 0; k < 8; k++) begin
         if (v[k]) begin
            len = 4'(k + 1);
         end
      end
      return len;
   endfunction

endpackage

@@ rtl/core/bwp_word_asm.sv @@
// Byte-to-word assembler that places packed bytes into result words.
module bwp_word_asm (
   input  logic                 clock,
   input  logic                 reset,
   input  bwp_pkg::asm_ctl_type ctl,
   input  logic [7:0]           push_byte,
   output logic                 rsp_strobe,
   output logic [63:0]          rsp_word,
   output logic [3:0]           rsp_valid_bytes,
   output logic                 rsp_last_res
);

   logic [63:0] word_ff, word_in;
   logic [3:0]  fill_ff, fill_in;
   logic        strobe_ff, strobe_in;
   logic [63:0] out_word_ff, out_word_in;
   logic [3:0]  out_valid_ff, out_valid_in;
   logic        out_last_ff, out_last_in;

   always_comb begin
      word_in      = word_ff;
      fill_in      = fill_ff;
      strobe_in    = 1'b0;
      out_word_in  = out_word_ff;
      out_valid_in = out_valid_ff;
      out_last_in  = out_last_ff;
      if (ctl.finish) begin
         strobe_in    = 1'b1;
         out_word_in  = word_ff;
         out_valid_in = fill_ff;
         out_last_in  = 1'b1;
         word_in      = 64'd0;
         fill_in      = 4'd0;
      end else if (ctl.push) begin
         if (fill_ff == 4'(bwp_pkg::BYTES_PER_WORD)) begin
            strobe_in    = 1'b1;
            out_word_in  = word_ff;
            out_valid_in = fill_ff;
            out_last_in  = 1'b0;
            word_in      = {push_byte, 56'd0};
            fill_in      = 4'd1;
         end else begin
            for (int k = 0; k < 8; k++) begin
               if (fill_ff[2:0] == 3'(k)) begin
                  word_in[63 - 8 * k -: 8] = push_byte;
               end
            end
            fill_in = fill_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff   <= 64'd0;
         fill_ff   <= 4'd0;
         strobe_ff <= 1'b0;
      end else begin
         word_ff   <= word_in;
         fill_ff   <= fill_in;
         strobe_ff <= strobe_in;
      end
      out_word_ff  <= out_word_in;
      out_valid_ff <= out_valid_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_word        = out_word_ff;
   assign rsp_valid_bytes = out_valid_ff;
   assign rsp_last_res    = out_last_ff;

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= 4'(bwp_pkg::BYTES_PER_WORD))
      else $error("Word fill count out of range.");

   a_full_middle: assert property (@(posedge clock) disable iff (reset)
      strobe_ff && !out_last_ff |-> out_valid_ff == 4'(bwp_pkg::BYTES_PER_WORD))
      else $error("A word that is not the last one is not full.");

   a_final_nonempty: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> out_valid_ff != 4'd0)
      else $error("A result word holds no bytes.");

   a_finish_clears: assert property (@(posedge clock) disable iff (reset)
      ctl.finish |=> fill_ff == 4'd0 && word_ff == 64'd0)
      else $error("The assembler was not cleared after the final word.");

endmodule

@@ rtl/core/bit_width_packer_top.sv @@
// Top level of the bit width packer: element store, packing sequencer and word assembler.
// Loading requests are taken back to back; busy stays low between them. After the final
// request busy stays high while the sequencer writes the count, reads each element for its
// length nibble, reads each element again to shift out its payload bits, flushes the partial
// byte and closes the word; for an empty set busy is high for one cycle. Results are one-cycle
// strobes that cannot be stalled; reset clears state, counters, strobe and assembly word, not the store.
module bit_width_packer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [7:0]  req_value,
   input  logic        req_last,
   input  logic        req_empty_set,
   output logic        rsp_strobe,
   output logic [63:0] rsp_word,
   output logic [3:0]  rsp_valid_bytes,
   output logic        rsp_last_res
);

   bwp_pkg::state_type   state_ff, state_in;
   bwp_pkg::asm_ctl_type ctl;
   logic [7:0] count_ff, count_in;
   logic [7:0] idx_ff, idx_in;
   logic [3:0] nib_hi_ff, nib_hi_in;
   logic [7:0] shreg_ff, shreg_in;
   logic [3:0] len_ff, len_in;
   logic [7:0] bitbuf_ff, bitbuf_in;
   logic [2:0] bitcnt_ff, bitcnt_in;
   logic [7:0] rdata_ff;
   logic [7:0] push_byte;
   logic [7:0] store [0:bwp_pkg::MAX_ELEMENTS - 1];
   logic       accept, store_we;
   logic       last_elem, data_bit;
   logic [3:0] rd_len, len_m1;

   assign accept    = start && (state_ff == bwp_pkg::ST_IDLE);
   assign busy      = (state_ff != bwp_pkg::ST_IDLE);
   assign store_we  = accept && !req_empty_set && (count_ff != 8'(bwp_pkg::MAX_ELEMENTS));
   assign last_elem = (idx_ff == count_ff - 8'd1);
   assign rd_len    = bwp_pkg::sig_len(rdata_ff);
   assign len_m1    = len_ff - 4'd1;
   assign data_bit  = shreg_ff[len_m1[2:0]];

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      nib_hi_in  = nib_hi_ff;
      shreg_in   = shreg_ff;
      len_in     = len_ff;
      bitbuf_in  = bitbuf_ff;
      bitcnt_in  = bitcnt_ff;
      ctl.push   = 1'b0;
      ctl.finish = 1'b0;
      push_byte  = 8'd0;
      unique case (state_ff)
         bwp_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_empty_set) begin
                  ctl.push = 1'b1;
                  count_in = 8'd0;
                  state_in = bwp_pkg::ST_FINISH;
               end else begin
                  if (store_we) begin
                     count_in = count_ff + 8'd1;
                  end
                  if (req_last) begin
                     state_in = bwp_pkg::ST_HEAD;
                  end
               end
            end
         end
         bwp_pkg::ST_HEAD: begin
            ctl.push  = 1'b1;
            push_byte = count_ff;
            idx_in    = 8'd0;
            state_in  = bwp_pkg::ST_NIB_RD;
         end
         bwp_pkg::ST_NIB_RD: begin
            state_in = bwp_pkg::ST_NIB_USE;
         end
         bwp_pkg::ST_NIB_USE: begin
            if (!idx_ff[0]) begin
               nib_hi_in = rd_len;
               if (last_elem) begin
                  ctl.push  = 1'b1;
                  push_byte = {rd_len, 4'd0};
               end
            end else begin
               ctl.push  = 1'b1;
               push_byte = {nib_hi_ff, rd_len};
            end
            if (last_elem) begin
               idx_in   = 8'd0;
               state_in = bwp_pkg::ST_PAY_RD;
            end else begin
               idx_in   = idx_ff + 8'd1;
               state_in = bwp_pkg::ST_NIB_RD;
            end
         end
         bwp_pkg::ST_PAY_RD: begin
            state_in = bwp_pkg::ST_PAY_LOAD;
         end
         bwp_pkg::ST_PAY_LOAD: begin
            shreg_in = rdata_ff;
            len_in   = rd_len;
            if (rd_len != 4'd0) begin
               state_in = bwp_pkg::ST_PAY_BIT;
            end else if (last_elem) begin
               state_in = bwp_pkg::ST_FLUSH;
            end else begin
               idx_in   = idx_ff + 8'd1;
               state_in = bwp_pkg::ST_PAY_RD;
            end
         end
         bwp_pkg::ST_PAY_BIT: begin
            bitbuf_in = {bitbuf_ff[6:0], data_bit};
            bitcnt_in = bitcnt_ff + 3'd1;
            len_in    = len_m1;
            if (bitcnt_ff == 3'd7) begin
               ctl.push  = 1'b1;
               push_byte = {bitbuf_ff[6:0], data_bit};
            end
            if (len_ff == 4'd1) begin
               if (last_elem) begin
                  state_in = bwp_pkg::ST_FLUSH;
               end else begin
                  idx_in   = idx_ff + 8'd1;
                  state_in = bwp_pkg::ST_PAY_RD;
               end
            end
         end
         bwp_pkg::ST_FLUSH: begin
            if (bitcnt_ff != 3'd0) begin
               ctl.push  = 1'b1;
               push_byte = bitbuf_ff << (3'd0 - bitcnt_ff);
            end
            bitcnt_in = 3'd0;
            state_in  = bwp_pkg::ST_FINISH;
         end
         bwp_pkg::ST_FINISH: begin
            ctl.finish = 1'b1;
            count_in   = 8'd0;
            state_in   = bwp_pkg::ST_IDLE;
         end
         default: begin
            state_in = bwp_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= bwp_pkg::ST_IDLE;
         count_ff  <= 8'd0;
         bitcnt_ff <= 3'd0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         bitcnt_ff <= bitcnt_in;
      end
      idx_ff    <= idx_in;
      nib_hi_ff <= nib_hi_in;
      shreg_ff  <= shreg_in;
      len_ff    <= len_in;
      bitbuf_ff <= bitbuf_in;
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         store[count_ff] <= req_value;
      end
      rdata_ff <= store[idx_ff];
   end

   bwp_word_asm u_word_asm (
      .clock           (clock),
      .reset           (reset),
      .ctl             (ctl),
      .push_byte       (push_byte),
      .rsp_strobe      (rsp_strobe),
      .rsp_word        (rsp_word),
      .rsp_valid_bytes (rsp_valid_bytes),
      .rsp_last_res    (rsp_last_res)
   );

endmodule

@@ dv/bit_width_packer_top_tb.sv @@
// Self-checking testbench of the bit width packer top level, driven by directed and random byte sets.
`timescale 1ns / 1ps
module bit_width_packer_top_tb;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned RANDOM_ITEMS = 185;
   localparam int unsigned DRAIN_CYCLES = 16;
   localparam int unsigned DIRECTED_ROWS = 25;

   typedef struct packed {
      logic [63:0] word;
      logic [3:0]  valid_bytes;
      logic        last_res;
   } packed_word_type;

   typedef struct packed {
      logic [7:0]      value;
      logic            is_last;
      logic            empty_set;
      logic            typed;
      packed_word_type result;
   } byte_request_type;

   typedef enum int unsigned {MIX_ANY, MIX_NARROW, MIX_EDGE, MIX_WIDE} value_mix_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [7:0]  req_value;
   logic        req_last;
   logic        req_empty_set;
   logic        rsp_strobe;
   logic [63:0] rsp_word;
   logic [3:0]  rsp_valid_bytes;
   logic        rsp_last_res;

   logic [7:0]      set_bytes [0:bwp_pkg::MAX_ELEMENTS-1];
   int unsigned     set_size = 0;
   packed_word_type pending_words [$];
   packed_word_type fresh_words [$];
   logic            typed_valid;
   packed_word_type typed_word;
   int unsigned     error_count = 0;
   int unsigned     request_count = 0;
   int unsigned     word_count = 0;
   int unsigned     set_count = 0;
   int unsigned     empty_count = 0;
   int unsigned     cycle_count = 0;

   bit_width_packer_top i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_value       (req_value),
      .req_last        (req_last),
      .req_empty_set   (req_empty_set),
      .rsp_strobe      (rsp_strobe),
      .rsp_word        (rsp_word),
      .rsp_valid_bytes (rsp_valid_bytes),
      .rsp_last_res    (rsp_last_res)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned bit_length(input logic [7:0] v);
      int unsigned len;
      len = 0;
      while ((v >> len) != 0) len++;
      return len;
   endfunction

   function automatic void predict_request(input logic [7:0] value, input logic is_last,
                                           input logic empty_set);
      logic [7:0]      stream [$];
      logic            payload [$];
      logic [7:0]      acc;
      packed_word_type w;
      int unsigned     pairs;
      int unsigned     hi;
      int unsigned     lo;
      int unsigned     len;
      int unsigned     total;
      fresh_words.delete();
      if (empty_set) begin
         w.word = 64'h0;
         w.valid_bytes = 4'd1;
         w.last_res = 1'b1;
         fresh_words.push_back(w);
         set_size = 0;
         return;
      end
      if (set_size < bwp_pkg::MAX_ELEMENTS) begin
         set_bytes[set_size] = value;
         set_size++;
      end
      if (!is_last) return;
      pairs = (set_size + 1) / 2;
      stream.push_back(8'(set_size));
      for (int i = 0; i < pairs; i++) begin
         hi = bit_length(set_bytes[2 * i]);
         lo = (2 * i + 1 < set_size) ? bit_length(set_bytes[2 * i + 1]) : 0;
         stream.push_back({4'(hi), 4'(lo)});
      end
      for (int i = 0; i < set_size; i++) begin
         len = bit_length(set_bytes[i]);
         for (int b = int'(len) - 1; b >= 0; b--) payload.push_back(set_bytes[i][b]);
      end
      for (int j = 0; j < payload.size(); j += 8) begin
         acc = 8'h00;
         for (int k = 0; k < 8; k++) begin
            if (j + k < payload.size()) acc[7 - k] = payload[j + k];
         end
         stream.push_back(acc);
      end
      total = stream.size();
      for (int base = 0; base < total; base += 8) begin
         w = '0;
         for (int b = 0; b < 8; b++) begin
            if (base + b < total) w.word[63 - 8 * b -: 8] = stream[base + b];
         end
         w.valid_bytes = 4'((total - base > 8) ? 8 : total - base);
         w.last_res = (base + 8 >= total);
         fresh_words.push_back(w);
      end
      set_size = 0;
   endfunction

   always @(posedge clock) begin
      packed_word_type want;
      if (!reset) begin
         if (rsp_strobe) begin
            word_count++;
            if (pending_words.size() == 0) begin
               error_count++;
               $display("%0t: unexpected word %h valid_bytes %0d last_res %b", $time,
                        rsp_word, rsp_valid_bytes, rsp_last_res);
            end else begin
               want = pending_words.pop_front();
               if (rsp_word !== want.word) begin
                  error_count++;
                  $display("%0t: word expected %h actual %h", $time, want.word, rsp_word);
               end
               if (rsp_valid_bytes !== want.valid_bytes) begin
                  error_count++;
                  $display("%0t: valid_bytes expected %0d actual %0d", $time,
                           want.valid_bytes, rsp_valid_bytes);
               end
               if (rsp_last_res !== want.last_res) begin
                  error_count++;
                  $display("%0t: last_res expected %b actual %b", $time,
                           want.last_res, rsp_last_res);
               end
            end
         end
         if (start && !busy) begin
            predict_request(req_value, req_last, req_empty_set);
            request_count++;
            if (req_empty_set) begin
               empty_count++;
            end else if (req_last) begin
               set_count++;
            end
            if (typed_valid) begin
               fresh_words.delete();
               fresh_words.push_back(typed_word);
            end
            foreach (fresh_words[i]) pending_words.push_back(fresh_words[i]);
         end
      end
   end

   task automatic send_request(input logic [7:0] value, input logic is_last,
                               input logic empty_set, input logic typed,
                               input packed_word_type result);
      @(negedge clock);
      start <= 1'b1;
      req_value <= value;
      req_last <= is_last;
      req_empty_set <= empty_set;
      typed_valid = typed;
      typed_word = result;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   task automatic hold_off(input int unsigned cycles);
      repeat (cycles) begin
         @(negedge clock);
         start <= 1'b0;
         req_value <= 8'($urandom);
         req_last <= 1'($urandom);
         req_empty_set <= 1'($urandom);
      end
   endtask

   task automatic maybe_idle(input bit calm);
      if (!calm && $urandom_range(0, 99) < 20) hold_off($urandom_range(1, 2));
   endtask

   function automatic logic [7:0] random_element(input value_mix_type mix);
      case (mix)
         MIX_NARROW: return 8'($urandom_range(0, 15));
         MIX_EDGE: begin
            case ($urandom_range(0, 3))
               0: return 8'h00;
               1: return 8'h01;
               2: return 8'h80;
               default: return 8'hFF;
            endcase
         end
         MIX_WIDE: return 8'h80 | 8'($urandom);
         default: return 8'($urandom);
      endcase
   endfunction

   initial begin
      byte_request_type directed_table [0:DIRECTED_ROWS-1];
      int unsigned      random_sent;
      int unsigned      set_len;
      bit               paused;
      bit               aborted;
      bit               calm;
      value_mix_type    mix;
      reset = 1'b1;
      start = 1'b0;
      req_value = 8'h00;
      req_last = 1'b0;
      req_empty_set = 1'b0;
      typed_valid = 1'b0;
      typed_word = '0;
      random_sent = 0;
      paused = 1'b0;
      directed_table = '{
         '{8'h00, 1'b0, 1'b1, 1'b1, '{64'h0000_0000_0000_0000, 4'd1, 1'b1}},
         '{8'hFF, 1'b1, 1'b1, 1'b1, '{64'h0000_0000_0000_0000, 4'd1, 1'b1}},
         '{8'h00, 1'b1, 1'b0, 1'b1, '{64'h0100_0000_0000_0000, 4'd2, 1'b1}},
         '{8'hFF, 1'b1, 1'b0, 1'b1, '{64'h0180_FF00_0000_0000, 4'd3, 1'b1}},
         '{8'h01, 1'b1, 1'b0, 1'b1, '{64'h0110_8000_0000_0000, 4'd3, 1'b1}},
         '{8'h80, 1'b1, 1'b0, 1'b1, '{64'h0180_8000_0000_0000, 4'd3, 1'b1}},
         '{8'h03, 1'b0, 1'b0, 1'b0, '{64'h0, 4'd0, 1'b0}},
         '{8'h07, 1'b0, 1'b0, 1'b0, '{64'h0, 4'd0, 1'b0}},
         '{8'hAA, 1'b0, 1'b1, 1'b1, '{64'h0000_0000_0000_0000, 4'd1, 1'b1}},
         '{8'h00, 1'b0, 1'b0, 1'b0, '{64'h0, 4'd0, 1'b0}},
         '{8'h00, 1'b0, 1'b0, 1'b0, '{64'h0, 4'd0, 1'b0}},
         '{8'h00, 1'b1, 1'b0, 1'b1, '{64'h0300_0000_0000_0000, 4'd3, 1'b1}},
         '{8'h55, 1'b0, 1'b0, 1'b0, '{64'h0, 4'd0, 1'b0}},
         '{8'hAA, 1'b0, 1'b0, 1'b0, '{64'h0, 4'd0, 1'b0}},
         '{8'h0F, 1'b0, 1'b0, 1'b0, '{64'h0, 4'd0, 1'b0}},
         '{8'hF0, 1'b0, 1'b0, 1'b0, '{64'h0, 4'd0, 1'b0}},
         '{8'h01, 1'b0, 1'b0, 1'b0, '{64'h0, 4'd0, 1'b0}},
         '{8'hFE, 1'b1, 1'b0, 1'b0, '{64'h0, 4'd0, 1'b0}},
         '{8'h80, 1'b0, 1'b0, 1'b0, '{64'h0, 4'd0, 1'b0}},
         '{8'h40, 1'b0, 1'b0, 1'b0, '{64'h0, 4'd0, 1'b0}},
         '{8'h20, 1'b0, 1'b0, 1'b0, '{64'h0, 4'd0, 1'b0}},
         '{8'h10, 1'b0, 1'b0, 1'b0, '{64'h0, 4'd0, 1'b0}},
         '{8'h08, 1'b0, 1'b0, 1'b0, '{64'h0, 4'd0, 1'b0}},
         '{8'h04, 1'b0, 1'b0, 1'b0, '{64'h0, 4'd0, 1'b0}},
         '{8'h02, 1'b1, 1'b0, 1'b0, '{64'h0, 4'd0, 1'b0}}
      };
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_table[i]) begin
         maybe_idle(1'b0);
         send_request(directed_table[i].value, directed_table[i].is_last,
                      directed_table[i].empty_set, directed_table[i].typed,
                      directed_table[i].result);
      end

      while (random_sent < RANDOM_ITEMS) begin
         calm = (random_sent >= 40 && random_sent < 90);
         if (!paused && random_sent >= 150) begin
            hold_off(1);
            while (pending_words.size() != 0) hold_off(1);
            paused = 1'b1;
         end
         if ($urandom_range(0, 11) == 0) begin
            maybe_idle(calm);
            send_request(8'($urandom), 1'($urandom), 1'b1, 1'b0, '0);
            random_sent++;
         end else begin
            set_len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                  : $urandom_range(1, 12);
            mix = value_mix_type'($urandom_range(0, 3));
            aborted = 1'b0;
            for (int i = 0; i < set_len && !aborted; i++) begin
               maybe_idle(calm);
               if (i > 0 && $urandom_range(0, 29) == 0) begin
                  send_request(8'($urandom), 1'($urandom), 1'b1, 1'b0, '0);
                  aborted = 1'b1;
               end else begin
                  send_request(random_element(mix), i == set_len - 1, 1'b0, 1'b0, '0);
               end
               random_sent++;
            end
         end
      end

      hold_off(1);
      while (pending_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d requests, closing %0d packed sets of mixed sizes and values",
               request_count, set_count);
      $display("and %0d empty sets; %0d result words checked, %0d failures.",
               empty_count, word_count, error_count);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: timeout after %0d cycles with %0d words outstanding", $time,
               cycle_count, pending_words.size());
      $display("status: fail");
      $finish;
   end

endmodule

@@ bit_width_packer_top.f @@
rtl/core/bwp_pkg.sv
rtl/core/bwp_word_asm.sv
rtl/core/bit_width_packer_top.sv
dv/bit_width_packer_top_tb.sv
